// ===== rtl/lav_pkg.sv =====
`default_nettype none
package lav_pkg;

    // magnitude width after scaling: largest component lands in [2^30, 2^31)
    localparam int MAG_BITS   = 31;
    localparam int SQRT_STEPS = 32;
    localparam int SUM_BITS   = 64;
    localparam int ELEM_BITS  = 32;
    localparam logic [1:0] LAST_COL = 2'd3;

    // round to f fewer fraction bits, half away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int f);
        logic [63:0] m;
        m = v[63] ? (~v + 64'd1) : v;
        m = (m + (64'd1 << (f - 1))) >> f;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > $signed(64'h0000_0000_7FFF_FFFF)) begin
            r = 32'h7FFF_FFFF;
        end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lav_norm.sv =====
`default_nettype none
module lav_norm #(
    parameter int W  = 33,
    parameter int F  = 16,
    parameter int PW = 1
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [2:0][W-1:0]       in_vec,
    input  wire logic [PW-1:0]           in_side,
    output logic                         out_valid,
    output logic [2:0][F+1:0]            out_vec,
    output logic                         out_degen,
    output logic [PW-1:0]                out_side
);

    localparam int MB = lav_pkg::MAG_BITS;
    localparam int SQ = lav_pkg::SQRT_STEPS;
    localparam int SB = lav_pkg::SUM_BITS;
    localparam int SW = $clog2(W);
    localparam int KW = PW + 4;
    localparam int LW = MB + 1;
    localparam int RW = LW + 1;
    localparam int NW = MB + F + 1;
    localparam int DS = F + 1;

    // keep layout: [2:0] signs, [3] zero, [KW-1:4] side
    logic              a_v_reg;
    logic [KW-1:0]     a_k_reg, a_k_next;
    logic [2:0][W-1:0] a_mag_reg, a_mag_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_mag_next[i] = in_vec[i][W-1] ? (~in_vec[i] + W'(1)) : in_vec[i];
        end
        a_k_next = {in_side, 1'b0, in_vec[2][W-1], in_vec[1][W-1], in_vec[0][W-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg   <= in_valid;
            a_k_reg   <= a_k_next;
            a_mag_reg <= a_mag_next;
        end
    end

    // largest magnitude
    logic              b_v_reg;
    logic [KW-1:0]     b_k_reg, b_k_next;
    logic [2:0][W-1:0] b_mag_reg;
    logic [W-1:0]      b_mx_reg, b_mx_next;

    always_comb begin
        b_mx_next = a_mag_reg[0];
        if (a_mag_reg[1] > b_mx_next) b_mx_next = a_mag_reg[1];
        if (a_mag_reg[2] > b_mx_next) b_mx_next = a_mag_reg[2];
        b_k_next    = a_k_reg;
        b_k_next[3] = (b_mx_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en) begin
            b_v_reg   <= a_v_reg;
            b_k_reg   <= b_k_next;
            b_mag_reg <= a_mag_reg;
            b_mx_reg  <= b_mx_next;
        end
    end

    // leading one position to shift amount
    logic              c_v_reg;
    logic [KW-1:0]     c_k_reg;
    logic [2:0][W-1:0] c_mag_reg;
    logic              c_right_reg, c_right_next;
    logic [SW-1:0]     c_amt_reg, c_amt_next;

    always_comb begin
        int p;
        p = 0;
        for (int i = 0; i < W; i++) begin
            if (b_mx_reg[i]) p = i;
        end
        c_right_next = (p > MB - 1);
        c_amt_next   = c_right_next ? SW'(p - (MB - 1)) : SW'((MB - 1) - p);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (en) begin
            c_v_reg     <= b_v_reg;
            c_k_reg     <= b_k_reg;
            c_mag_reg   <= b_mag_reg;
            c_right_reg <= c_right_next;
            c_amt_reg   <= c_amt_next;
        end
    end

    // scale all three by the common power of two
    logic               d_v_reg;
    logic [KW-1:0]      d_k_reg;
    logic [2:0][MB-1:0] d_m_reg, d_m_next;

    always_comb begin
        logic [W-1:0] t;
        t = '0;
        for (int i = 0; i < 3; i++) begin
            t = c_right_reg ? (c_mag_reg[i] >> c_amt_reg) : (c_mag_reg[i] << c_amt_reg);
            d_m_next[i] = t[MB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
        end else if (en) begin
            d_v_reg <= c_v_reg;
            d_k_reg <= c_k_reg;
            d_m_reg <= d_m_next;
        end
    end

    // squares
    logic                 e_v_reg;
    logic [KW-1:0]        e_k_reg;
    logic [2:0][MB-1:0]   e_m_reg;
    logic [2:0][2*MB-1:0] e_sq_reg, e_sq_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_sq_next[i] = (2 * MB)'(d_m_reg[i]) * (2 * MB)'(d_m_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_v_reg <= 1'b0;
        end else if (en) begin
            e_v_reg  <= d_v_reg;
            e_k_reg  <= d_k_reg;
            e_m_reg  <= d_m_reg;
            e_sq_reg <= e_sq_next;
        end
    end

    // square root, one bit pair per stage; entry 0 holds the sum
    logic               sq_v_reg [0:SQ];
    logic [KW-1:0]      sq_k_reg [0:SQ];
    logic [2:0][MB-1:0] sq_m_reg [0:SQ];
    logic [SB-1:0]      sq_s_reg [0:SQ];
    logic [SB-1:0]      sq_r_reg [0:SQ];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= e_v_reg;
            sq_k_reg[0] <= e_k_reg;
            sq_m_reg[0] <= e_m_reg;
            sq_s_reg[0] <= SB'(e_sq_reg[0]) + SB'(e_sq_reg[1]) + SB'(e_sq_reg[2]);
            sq_r_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        logic [SB-1:0] s_next, r_next, t;
        localparam logic [SB-1:0] BIT = SB'(1) << (SB - 2 - 2 * k);

        always_comb begin
            t = sq_r_reg[k] + BIT;
            if (sq_s_reg[k] >= t) begin
                s_next = sq_s_reg[k] - t;
                r_next = (sq_r_reg[k] >> 1) + BIT;
            end else begin
                s_next = sq_s_reg[k];
                r_next = sq_r_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[k+1] <= sq_v_reg[k];
                sq_k_reg[k+1] <= sq_k_reg[k];
                sq_m_reg[k+1] <= sq_m_reg[k];
                sq_s_reg[k+1] <= s_next;
                sq_r_reg[k+1] <= r_next;
            end
        end
    end

    // restoring division, one quotient bit per stage; entry 0 is setup
    logic               dv_v_reg   [0:DS];
    logic [KW-1:0]      dv_k_reg   [0:DS];
    logic [LW-1:0]      dv_len_reg [0:DS];
    logic [2:0][NW-1:0] dv_num_reg [0:DS];
    logic [2:0][RW-1:0] dv_rem_reg [0:DS];
    logic [2:0][DS-1:0] dv_q_reg   [0:DS];

    logic [LW-1:0]      dv_len_next;
    logic [2:0][NW-1:0] dv_num_next;
    logic [2:0][RW-1:0] dv_rem_next;

    always_comb begin
        dv_len_next = sq_r_reg[SQ][LW-1:0];
        for (int i = 0; i < 3; i++) begin
            dv_num_next[i] = NW'({sq_m_reg[SQ][i], {F{1'b0}}}) + NW'(dv_len_next >> 1);
            dv_rem_next[i] = RW'(dv_num_next[i] >> (F + 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0]   <= sq_v_reg[SQ];
            dv_k_reg[0]   <= sq_k_reg[SQ];
            dv_len_reg[0] <= dv_len_next;
            dv_num_reg[0] <= dv_num_next;
            dv_rem_reg[0] <= dv_rem_next;
            dv_q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < DS; k++) begin : g_div
        logic [2:0][RW-1:0] rem_next;
        logic [2:0][DS-1:0] q_next;

        always_comb begin
            logic [RW-1:0] r2;
            r2 = '0;
            for (int i = 0; i < 3; i++) begin
                r2 = {dv_rem_reg[k][i][RW-2:0], dv_num_reg[k][i][F-k]};
                if (r2 >= RW'(dv_len_reg[k])) begin
                    rem_next[i] = r2 - RW'(dv_len_reg[k]);
                    q_next[i]   = {dv_q_reg[k][i][DS-2:0], 1'b1};
                end else begin
                    rem_next[i] = r2;
                    q_next[i]   = {dv_q_reg[k][i][DS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[k+1]   <= dv_v_reg[k];
                dv_k_reg[k+1]   <= dv_k_reg[k];
                dv_len_reg[k+1] <= dv_len_reg[k];
                dv_num_reg[k+1] <= dv_num_reg[k];
                dv_rem_reg[k+1] <= rem_next;
                dv_q_reg[k+1]   <= q_next;
            end
        end
    end

    // restore signs, zero the axis of a zero-length vector
    logic              o_v_reg;
    logic [2:0][F+1:0] o_vec_reg, o_vec_next;
    logic              o_degen_reg;
    logic [PW-1:0]     o_side_reg;

    always_comb begin
        logic [F+1:0] q;
        q = '0;
        for (int i = 0; i < 3; i++) begin
            q = (F + 2)'(dv_q_reg[DS][i]);
            if (dv_k_reg[DS][3]) begin
                o_vec_next[i] = '0;
            end else begin
                o_vec_next[i] = dv_k_reg[DS][i] ? (~q + (F + 2)'(1)) : q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_v_reg <= 1'b0;
        end else if (en) begin
            o_v_reg     <= dv_v_reg[DS];
            o_vec_reg   <= o_vec_next;
            o_degen_reg <= dv_k_reg[DS][3];
            o_side_reg  <= dv_k_reg[DS][KW-1:4];
        end
    end

    assign out_valid = o_v_reg;
    assign out_vec   = o_vec_reg;
    assign out_degen = o_degen_reg;
    assign out_side  = o_side_reg;

endmodule
`default_nettype wire

// ===== rtl/look_at_view_matrix_top.sv =====
`default_nettype none
// Right-handed look-at view matrix, signed fixed point with FRAC_BITS fraction bits.
// Input channel s_axis: one beat carries eye, target and up (nine 32-bit fields).
// Output channel m_axis: four beats per input, one matrix column each, column 0 first;
// tlast marks column 3, tuser carries the column index and the degenerate flag.
// Each normalizer is a pipeline of a 32-stage square root and a FRAC_BITS+1 stage
// divider, with one stage per iteration. Sustained throughput is bounded by the four
// output beats per matrix; the pipeline itself takes a beat every cycle while the
// serializer does not stall it, and holds many matrices.
// Reset (aresetn low, synchronous) clears all valid bits and the column counter;
// no matrix in flight survives it.
// When the receiver stalls, the whole pipeline holds once its last stage is full;
// s_axis_tready then drops, and nothing is lost or repeated.
module look_at_view_matrix_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  wire logic [287:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // elem_row0, elem_row1, elem_row2, elem_row3
    output logic [127:0]      m_axis_tdata,
    // column_index[1:0], degenerate[2]
    output logic [2:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int F   = FRAC_BITS;
    localparam int EB  = lav_pkg::ELEM_BITS;
    localparam int NB  = F + 2;
    localparam int PB  = NB + EB;
    localparam int TW  = PB + 1;
    localparam int YPB = 2 * NB;
    localparam int YW  = F + 3;
    localparam int PW1 = 6 * EB;
    localparam int PW2 = 3 * EB + 3 * NB + 1;

    logic en;
    logic load;

    // input stage
    logic               i_v_reg;
    logic [2:0][EB-1:0] i_eye_reg, i_up_reg;
    logic [2:0][EB:0]   i_dir_reg, i_dir_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            i_dir_next[i] = (EB + 1)'($signed(s_axis_tdata[(3 + i) * EB +: EB]))
                          - (EB + 1)'($signed(s_axis_tdata[i * EB +: EB]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_v_reg <= 1'b0;
        end else if (en) begin
            i_v_reg   <= s_axis_tvalid;
            i_eye_reg <= s_axis_tdata[3 * EB - 1:0];
            i_up_reg  <= s_axis_tdata[9 * EB - 1:6 * EB];
            i_dir_reg <= i_dir_next;
        end
    end

    // z axis
    logic               n1_v;
    logic [2:0][NB-1:0] n1_z;
    logic               n1_degen;
    logic [PW1-1:0]     n1_side;

    lav_norm #(.W(EB + 1), .F(F), .PW(PW1)) u_norm_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (i_v_reg),
        .in_vec    (i_dir_reg),
        .in_side   ({i_eye_reg, i_up_reg}),
        .out_valid (n1_v),
        .out_vec   (n1_z),
        .out_degen (n1_degen),
        .out_side  (n1_side)
    );

    // cross(z, up): products, then differences
    logic                   p_v_reg;
    logic [5:0][PB-1:0]     p_prod_reg, p_prod_next;
    logic [2:0][NB-1:0]     p_z_reg;
    logic [2:0][EB-1:0]     p_eye_reg, p_up;
    logic                   p_degen_reg;

    assign p_up = n1_side[EB * 3 - 1:0];

    always_comb begin
        p_prod_next[0] = PB'($signed(n1_z[1]) * $signed(p_up[2]));
        p_prod_next[1] = PB'($signed(n1_z[2]) * $signed(p_up[1]));
        p_prod_next[2] = PB'($signed(n1_z[2]) * $signed(p_up[0]));
        p_prod_next[3] = PB'($signed(n1_z[0]) * $signed(p_up[2]));
        p_prod_next[4] = PB'($signed(n1_z[0]) * $signed(p_up[1]));
        p_prod_next[5] = PB'($signed(n1_z[1]) * $signed(p_up[0]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (en) begin
            p_v_reg     <= n1_v;
            p_prod_reg  <= p_prod_next;
            p_z_reg     <= n1_z;
            p_eye_reg   <= n1_side[PW1-1:3 * EB];
            p_degen_reg <= n1_degen;
        end
    end

    logic               q_v_reg;
    logic [2:0][TW-1:0] q_tmp_reg, q_tmp_next;
    logic [2:0][NB-1:0] q_z_reg;
    logic [2:0][EB-1:0] q_eye_reg;
    logic               q_degen_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_tmp_next[i] = TW'($signed(p_prod_reg[2 * i])) - TW'($signed(p_prod_reg[2 * i + 1]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_v_reg <= 1'b0;
        end else if (en) begin
            q_v_reg     <= p_v_reg;
            q_tmp_reg   <= q_tmp_next;
            q_z_reg     <= p_z_reg;
            q_eye_reg   <= p_eye_reg;
            q_degen_reg <= p_degen_reg;
        end
    end

    // x axis
    logic               n2_v;
    logic [2:0][NB-1:0] n2_x;
    logic               n2_degen;
    logic [PW2-1:0]     n2_side;

    lav_norm #(.W(TW), .F(F), .PW(PW2)) u_norm_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_v_reg),
        .in_vec    (q_tmp_reg),
        .in_side   ({q_eye_reg, q_z_reg, q_degen_reg}),
        .out_valid (n2_v),
        .out_vec   (n2_x),
        .out_degen (n2_degen),
        .out_side  (n2_side)
    );

    logic [2:0][NB-1:0] n2_z;
    logic [2:0][EB-1:0] n2_eye;

    assign n2_z   = n2_side[3 * NB:1];
    assign n2_eye = n2_side[PW2-1:3 * NB + 1];

    // products for y and for the x and z dots
    logic                r_v_reg;
    logic [5:0][YPB-1:0] r_yp_reg, r_yp_next;
    logic [2:0][PB-1:0]  r_xe_reg, r_xe_next, r_ze_reg, r_ze_next;
    logic [2:0][NB-1:0]  r_x_reg, r_z_reg;
    logic [2:0][EB-1:0]  r_eye_reg;
    logic                r_degen_reg;

    always_comb begin
        r_yp_next[0] = YPB'($signed(n2_x[1]) * $signed(n2_z[2]));
        r_yp_next[1] = YPB'($signed(n2_x[2]) * $signed(n2_z[1]));
        r_yp_next[2] = YPB'($signed(n2_x[2]) * $signed(n2_z[0]));
        r_yp_next[3] = YPB'($signed(n2_x[0]) * $signed(n2_z[2]));
        r_yp_next[4] = YPB'($signed(n2_x[0]) * $signed(n2_z[1]));
        r_yp_next[5] = YPB'($signed(n2_x[1]) * $signed(n2_z[0]));
        for (int i = 0; i < 3; i++) begin
            r_xe_next[i] = PB'($signed(n2_x[i]) * $signed(n2_eye[i]));
            r_ze_next[i] = PB'($signed(n2_z[i]) * $signed(n2_eye[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_v_reg <= 1'b0;
        end else if (en) begin
            r_v_reg     <= n2_v;
            r_yp_reg    <= r_yp_next;
            r_xe_reg    <= r_xe_next;
            r_ze_reg    <= r_ze_next;
            r_x_reg     <= n2_x;
            r_z_reg     <= n2_z;
            r_eye_reg   <= n2_eye;
            r_degen_reg <= n2_degen | n2_side[0];
        end
    end

    // y = rounded cross(x, z); sum the x and z dots
    logic               s_v_reg;
    logic [2:0][YW-1:0] s_y_reg, s_y_next;
    logic signed [63:0] s_dx_reg, s_dx_next, s_dz_reg, s_dz_next;
    logic [2:0][NB-1:0] s_x_reg, s_z_reg;
    logic [2:0][EB-1:0] s_eye_reg;
    logic               s_degen_reg;

    always_comb begin
        logic signed [63:0] d;
        d = '0;
        for (int i = 0; i < 3; i++) begin
            d = 64'($signed(r_yp_reg[2 * i])) - 64'($signed(r_yp_reg[2 * i + 1]));
            s_y_next[i] = YW'(lav_pkg::rnd_shift(d, F));
        end
        s_dx_next = 64'($signed(r_xe_reg[0])) + 64'($signed(r_xe_reg[1]))
                  + 64'($signed(r_xe_reg[2]));
        s_dz_next = 64'($signed(r_ze_reg[0])) + 64'($signed(r_ze_reg[1]))
                  + 64'($signed(r_ze_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_v_reg <= 1'b0;
        end else if (en) begin
            s_v_reg     <= r_v_reg;
            s_y_reg     <= s_y_next;
            s_dx_reg    <= s_dx_next;
            s_dz_reg    <= s_dz_next;
            s_x_reg     <= r_x_reg;
            s_z_reg     <= r_z_reg;
            s_eye_reg   <= r_eye_reg;
            s_degen_reg <= r_degen_reg;
        end
    end

    // y dot products; finish the x and z dots
    localparam int YEB = YW + EB;

    logic                t_v_reg;
    logic [2:0][YEB-1:0] t_ye_reg, t_ye_next;
    logic [EB-1:0]       t_dx_reg, t_dz_reg;
    logic [2:0][NB-1:0]  t_x_reg, t_z_reg;
    logic [2:0][YW-1:0]  t_y_reg;
    logic                t_degen_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t_ye_next[i] = YEB'($signed(s_y_reg[i]) * $signed(s_eye_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_v_reg <= 1'b0;
        end else if (en) begin
            t_v_reg     <= s_v_reg;
            t_ye_reg    <= t_ye_next;
            t_dx_reg    <= lav_pkg::sat32(-lav_pkg::rnd_shift(s_dx_reg, F));
            t_dz_reg    <= lav_pkg::sat32(lav_pkg::rnd_shift(s_dz_reg, F));
            t_x_reg     <= s_x_reg;
            t_z_reg     <= s_z_reg;
            t_y_reg     <= s_y_reg;
            t_degen_reg <= s_degen_reg;
        end
    end

    logic               u_v_reg;
    logic signed [63:0] u_dy_reg;
    logic [EB-1:0]      u_dx_reg, u_dz_reg;
    logic [2:0][NB-1:0] u_x_reg, u_z_reg;
    logic [2:0][YW-1:0] u_y_reg;
    logic               u_degen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_v_reg <= 1'b0;
        end else if (en) begin
            u_v_reg     <= t_v_reg;
            u_dy_reg    <= 64'($signed(t_ye_reg[0])) + 64'($signed(t_ye_reg[1]))
                         + 64'($signed(t_ye_reg[2]));
            u_dx_reg    <= t_dx_reg;
            u_dz_reg    <= t_dz_reg;
            u_x_reg     <= t_x_reg;
            u_z_reg     <= t_z_reg;
            u_y_reg     <= t_y_reg;
            u_degen_reg <= t_degen_reg;
        end
    end

    // last pipeline stage
    logic               v_v_reg;
    logic [EB-1:0]      v_dx_reg, v_dy_reg, v_dz_reg;
    logic [2:0][NB-1:0] v_x_reg, v_z_reg;
    logic [2:0][YW-1:0] v_y_reg;
    logic               v_degen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_v_reg <= 1'b0;
        end else if (en) begin
            v_v_reg     <= u_v_reg;
            v_dy_reg    <= lav_pkg::sat32(-lav_pkg::rnd_shift(u_dy_reg, F));
            v_dx_reg    <= u_dx_reg;
            v_dz_reg    <= u_dz_reg;
            v_x_reg     <= u_x_reg;
            v_z_reg     <= u_z_reg;
            v_y_reg     <= u_y_reg;
            v_degen_reg <= u_degen_reg;
        end
    end

    // column serializer
    logic               busy_reg, busy_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [EB-1:0]      o_dx_reg, o_dy_reg, o_dz_reg;
    logic [2:0][NB-1:0] o_x_reg, o_z_reg;
    logic [2:0][YW-1:0] o_y_reg;
    logic               o_degen_reg;
    logic               take;

    assign take = busy_reg && m_axis_tready;
    assign load = v_v_reg && (!busy_reg || (take && cnt_reg == lav_pkg::LAST_COL));
    assign en   = !v_v_reg || load;
    assign s_axis_tready = en;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (take) begin
            if (cnt_reg == lav_pkg::LAST_COL) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            o_dx_reg    <= v_dx_reg;
            o_dy_reg    <= v_dy_reg;
            o_dz_reg    <= v_dz_reg;
            o_x_reg     <= v_x_reg;
            o_y_reg     <= v_y_reg;
            o_z_reg     <= v_z_reg;
            o_degen_reg <= v_degen_reg;
        end
    end

    always_comb begin
        if (cnt_reg == lav_pkg::LAST_COL) begin
            m_axis_tdata = {EB'(1) << F, o_dz_reg, o_dy_reg, o_dx_reg};
        end else begin
            m_axis_tdata = {EB'(0),
                            EB'(-$signed(o_z_reg[cnt_reg])),
                            EB'($signed(o_y_reg[cnt_reg])),
                            EB'($signed(o_x_reg[cnt_reg]))};
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tuser  = {o_degen_reg, cnt_reg};
    assign m_axis_tlast  = (cnt_reg == lav_pkg::LAST_COL);

    // input may stall only behind a full last stage waiting on the serializer
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> v_v_reg && busy_reg)
        else $error("input stalled without a blocked matrix");

    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_axis_tvalid && cnt_reg == 2'd0)
        else $error("loaded matrix does not start at column 0");

    a_col_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        take && cnt_reg != lav_pkg::LAST_COL |=>
            m_axis_tvalid && cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("column sequence broken");

endmodule
`default_nettype wire
